// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// HBTE_ASSERT checks a property outside of reset; HBTE_ASSERT_RST also
// checks it while reset is applied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HBTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define HBTE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/hbte_pkg.sv =====
// ----------------------------------------------------------------------------
// hbte_pkg
// Shared types, byte constants and the decimal digit conversion of the
// half-block truecolor text encoder.
// ----------------------------------------------------------------------------
package hbte_pkg;

  // Default depth of the command queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;

  // Input transaction: one text cell
  typedef struct packed {
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] bottom_red;
    logic [7:0] bottom_green;
    logic [7:0] bottom_blue;
    logic       bottom_absent;
    logic       row_end;
  } cell_t;

  // Output transaction: one byte of the terminal stream
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } result_t;

  // One color channel in decimal, with flags for the leading digits
  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic       hund_vld;
    logic       tens_vld;
  } dec_t;

  typedef struct packed {
    dec_t red;
    dec_t green;
    dec_t blue;
  } rgb_dec_t;

  // Classified cell handed from front to back
  typedef struct packed {
    logic     fg_en;
    logic     bg_en;
    logic     row_end;
    rgb_dec_t fg;
    rgb_dec_t bg;
  } cmd_t;

  // Bytes of the stream
  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_SEMI     = 8'h3B;
  localparam logic [7:0] BYTE_M        = 8'h6D;
  localparam logic [7:0] BYTE_ZERO     = 8'h30;
  localparam logic [7:0] BYTE_TWO      = 8'h32;
  localparam logic [7:0] BYTE_THREE    = 8'h33;
  localparam logic [7:0] BYTE_FOUR     = 8'h34;
  localparam logic [7:0] BYTE_EIGHT    = 8'h38;
  localparam logic [7:0] BYTE_NEWLINE  = 8'h0A;
  localparam logic [7:0] GLYPH_0       = 8'hE2;
  localparam logic [7:0] GLYPH_1       = 8'h96;
  localparam logic [7:0] GLYPH_2       = 8'h80;

  // 8-bit value to three decimal digits; tens by reciprocal multiply (x205 >> 11)
  function automatic dec_t to_dec(logic [7:0] v);
    dec_t        d;
    logic [1:0]  h;
    logic [7:0]  rem8;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem8 = v - (8'(h) * 8'd100);
    r    = rem8[6:0];
    prod = 15'(r) * 15'd205;
    t    = prod[14:11];
    d.hund     = {2'b00, h};
    d.tens     = t;
    d.ones     = 4'(r - (7'(t) * 7'd10));
    d.hund_vld = (h != 2'd0);
    d.tens_vld = (h != 2'd0) || (t != 4'd0);
    return d;
  endfunction

endpackage

// ===== design/hbte_fifo.sv =====
// ----------------------------------------------------------------------------
// hbte_fifo
// Short command queue between front and back; head is read directly.
// Depth must be 2 or more.
// ----------------------------------------------------------------------------
module hbte_fifo #(
  parameter int unsigned Depth = hbte_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hbte_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output hbte_pkg::cmd_t data_o,
  output logic           valid_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  hbte_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/hbte_front.sv =====
// ----------------------------------------------------------------------------
// hbte_front
// Accepts cells, decides which color escapes are needed against the
// remembered row colors and converts the colors to decimal digits.
// ----------------------------------------------------------------------------
module hbte_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  hbte_pkg::cell_t cell_i,
  input  logic            cmd_full_i,
  output logic            cmd_push_o,
  output hbte_pkg::cmd_t  cmd_o
);

  logic        fore_known_q, fore_known_d;
  logic        back_known_q, back_known_d;
  logic [23:0] fore_color_q, fore_color_d;
  logic [23:0] back_color_q, back_color_d;
  logic [23:0] top_rgb, bot_rgb;
  logic        accept;

  assign accept     = push && !cmd_full_i;
  assign cmd_push_o = accept;

  // Missing lower pixel counts as black
  assign top_rgb = {cell_i.top_red, cell_i.top_green, cell_i.top_blue};
  assign bot_rgb = cell_i.bottom_absent ? 24'd0 :
                   {cell_i.bottom_red, cell_i.bottom_green, cell_i.bottom_blue};

  // Classification and decimal conversion
  always_comb begin
    cmd_o.fg_en     = !fore_known_q || (top_rgb != fore_color_q);
    cmd_o.bg_en     = !back_known_q || (bot_rgb != back_color_q);
    cmd_o.row_end   = cell_i.row_end;
    cmd_o.fg.red    = hbte_pkg::to_dec(top_rgb[23:16]);
    cmd_o.fg.green  = hbte_pkg::to_dec(top_rgb[15:8]);
    cmd_o.fg.blue   = hbte_pkg::to_dec(top_rgb[7:0]);
    cmd_o.bg.red    = hbte_pkg::to_dec(bot_rgb[23:16]);
    cmd_o.bg.green  = hbte_pkg::to_dec(bot_rgb[15:8]);
    cmd_o.bg.blue   = hbte_pkg::to_dec(bot_rgb[7:0]);
  end

  // Row color memory; row end forgets everything
  always_comb begin
    fore_known_d = fore_known_q;
    back_known_d = back_known_q;
    fore_color_d = fore_color_q;
    back_color_d = back_color_q;
    if (accept) begin
      if (cell_i.row_end) begin
        fore_known_d = 1'b0;
        back_known_d = 1'b0;
        fore_color_d = '0;
        back_color_d = '0;
      end else begin
        fore_known_d = 1'b1;
        back_known_d = 1'b1;
        fore_color_d = top_rgb;
        back_color_d = bot_rgb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_known_q <= 1'b0;
      back_known_q <= 1'b0;
      fore_color_q <= '0;
      back_color_q <= '0;
    end else begin
      fore_known_q <= fore_known_d;
      back_known_q <= back_known_d;
      fore_color_q <= fore_color_d;
      back_color_q <= back_color_d;
    end
  end

endmodule

// ===== design/hbte_back.sv =====
// ----------------------------------------------------------------------------
// hbte_back
// Byte sequencer: walks the segments of the head command (foreground
// escape, background escape, glyph, row reset) into the output register,
// one byte per cycle while it is empty or popped, skipping leading zero digits.
// ----------------------------------------------------------------------------
module hbte_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbte_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output logic              empty,
  input  logic              pop,
  output hbte_pkg::result_t result_o
);

  // Segment codes
  localparam logic [1:0] SEG_FG  = 2'd0;
  localparam logic [1:0] SEG_BG  = 2'd1;
  localparam logic [1:0] SEG_GLY = 2'd2;
  localparam logic [1:0] SEG_RST = 2'd3;

  // Escape slot positions
  localparam logic [4:0] SLOT_RH   = 5'd7;
  localparam logic [4:0] SLOT_RT   = 5'd8;
  localparam logic [4:0] SLOT_RO   = 5'd9;
  localparam logic [4:0] SLOT_GH   = 5'd11;
  localparam logic [4:0] SLOT_GT   = 5'd12;
  localparam logic [4:0] SLOT_GO   = 5'd13;
  localparam logic [4:0] SLOT_BH   = 5'd15;
  localparam logic [4:0] SLOT_BT   = 5'd16;
  localparam logic [4:0] SLOT_BO   = 5'd17;
  localparam logic [4:0] ESC_LAST  = 5'd18;
  localparam logic [4:0] GLY_LAST  = 5'd2;
  localparam logic [4:0] RST_LAST  = 5'd4;

  logic [1:0]        seg_q, seg_d, seg_eff;
  logic [4:0]        slot_q, slot_d;
  logic [4:0]        n1, n2, n3, slot_next, seg_last;
  logic              out_vld_q, out_vld_d;
  hbte_pkg::result_t out_q, out_d;
  hbte_pkg::rgb_dec_t rgb;
  logic              advance, pop_fire, seg_done, item_done;
  logic [7:0]        cur_byte;
  logic [7:0]        layer;

  function automatic logic slot_ok(logic [4:0] s, hbte_pkg::rgb_dec_t c);
    logic ok;
    case (s)
      SLOT_RH: ok = c.red.hund_vld;
      SLOT_RT: ok = c.red.tens_vld;
      SLOT_GH: ok = c.green.hund_vld;
      SLOT_GT: ok = c.green.tens_vld;
      SLOT_BH: ok = c.blue.hund_vld;
      SLOT_BT: ok = c.blue.tens_vld;
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic [7:0] digit(logic [3:0] d);
    return hbte_pkg::BYTE_ZERO | {4'b0000, d};
  endfunction

  // Skip segments the command does not need
  always_comb begin
    seg_eff = seg_q;
    if (seg_eff == SEG_FG && !cmd_i.fg_en) begin
      seg_eff = SEG_BG;
    end
    if (seg_eff == SEG_BG && !cmd_i.bg_en) begin
      seg_eff = SEG_GLY;
    end
  end

  assign rgb   = (seg_eff == SEG_FG) ? cmd_i.fg : cmd_i.bg;
  assign layer = (seg_eff == SEG_FG) ? hbte_pkg::BYTE_THREE : hbte_pkg::BYTE_FOUR;

  // Byte at the current slot
  always_comb begin
    cur_byte = hbte_pkg::BYTE_ZERO;
    case (seg_eff)
      SEG_FG, SEG_BG: begin
        case (slot_q)
          5'd0:    cur_byte = hbte_pkg::BYTE_ESC;
          5'd1:    cur_byte = hbte_pkg::BYTE_LBRACKET;
          5'd2:    cur_byte = layer;
          5'd3:    cur_byte = hbte_pkg::BYTE_EIGHT;
          5'd5:    cur_byte = hbte_pkg::BYTE_TWO;
          SLOT_RH: cur_byte = digit(rgb.red.hund);
          SLOT_RT: cur_byte = digit(rgb.red.tens);
          SLOT_RO: cur_byte = digit(rgb.red.ones);
          SLOT_GH: cur_byte = digit(rgb.green.hund);
          SLOT_GT: cur_byte = digit(rgb.green.tens);
          SLOT_GO: cur_byte = digit(rgb.green.ones);
          SLOT_BH: cur_byte = digit(rgb.blue.hund);
          SLOT_BT: cur_byte = digit(rgb.blue.tens);
          SLOT_BO: cur_byte = digit(rgb.blue.ones);
          ESC_LAST: cur_byte = hbte_pkg::BYTE_M;
          default: cur_byte = hbte_pkg::BYTE_SEMI;
        endcase
      end
      SEG_GLY: begin
        case (slot_q)
          5'd0:    cur_byte = hbte_pkg::GLYPH_0;
          5'd1:    cur_byte = hbte_pkg::GLYPH_1;
          default: cur_byte = hbte_pkg::GLYPH_2;
        endcase
      end
      default: begin
        case (slot_q)
          5'd0:    cur_byte = hbte_pkg::BYTE_ESC;
          5'd1:    cur_byte = hbte_pkg::BYTE_LBRACKET;
          5'd2:    cur_byte = hbte_pkg::BYTE_ZERO;
          5'd3:    cur_byte = hbte_pkg::BYTE_M;
          default: cur_byte = hbte_pkg::BYTE_NEWLINE;
        endcase
      end
    endcase
  end

  // End of segment and of the whole cell
  always_comb begin
    case (seg_eff)
      SEG_FG, SEG_BG: seg_last = ESC_LAST;
      SEG_GLY:        seg_last = GLY_LAST;
      default:        seg_last = RST_LAST;
    endcase
  end

  assign seg_done  = (slot_q == seg_last);
  assign item_done = seg_done &&
                     ((seg_eff == SEG_RST) || (seg_eff == SEG_GLY && !cmd_i.row_end));

  // Next present slot; at most two digit slots in a row are skipped
  assign n1 = slot_q + 5'd1;
  assign n2 = slot_q + 5'd2;
  assign n3 = slot_q + 5'd3;
  assign slot_next = slot_ok(n1, rgb) ? n1 : (slot_ok(n2, rgb) ? n2 : n3);

  // Output register handshake
  assign pop_fire  = pop && out_vld_q;
  assign advance   = cmd_valid_i && (!out_vld_q || pop_fire);
  assign cmd_pop_o = advance && item_done;
  assign empty     = !out_vld_q;
  assign result_o  = out_q;

  always_comb begin
    seg_d     = seg_q;
    slot_d    = slot_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (pop_fire) begin
      out_vld_d = 1'b0;
    end
    if (advance) begin
      out_vld_d          = 1'b1;
      out_d.out_byte     = cur_byte;
      out_d.last_byte    = item_done;
      if (item_done) begin
        seg_d  = SEG_FG;
        slot_d = '0;
      end else if (seg_done) begin
        seg_d  = seg_eff + 2'd1;
        slot_d = '0;
      end else begin
        seg_d  = seg_eff;
        slot_d = slot_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q     <= SEG_FG;
      slot_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      seg_q     <= seg_d;
      slot_q    <= slot_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== design/half_block_truecolor_text_encoder.sv =====
// ----------------------------------------------------------------------------
// half_block_truecolor_text_encoder
// Turns cells of two RGB pixels into the truecolor terminal byte stream of
// upper-half-block glyphs.
// ----------------------------------------------------------------------------
// Each cell produces between 3 and 46 bytes (glyph only, up to two color
// escapes of 13 to 19 bytes each, plus 5 bytes at row end), and the block
// sends one byte per clock while the receiver keeps popping; the byte
// sequencer in the back end sets this rate. Cells are classified on entry
// and wait in a queue of FifoDepth entries, so push keeps being taken, while
// the queue has room, as earlier cells are still being sent; the last result
// byte of each cell is flagged with last_byte.
module half_block_truecolor_text_encoder #(
  parameter int unsigned FifoDepth = hbte_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  hbte_pkg::cell_t   cell_i,
  output logic              empty,
  input  logic              pop,
  output hbte_pkg::result_t result_o
);

  hbte_pkg::cmd_t cmd_in, cmd_head;
  logic           cmd_push, cmd_pop, cmd_valid;

  // Front: accept and classify
  hbte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .cell_i     (cell_i),
    .cmd_full_i (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Command queue
  hbte_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .valid_o (cmd_valid)
  );

  // Back: byte sequencer and output register
  hbte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

// ===== design/hbte_checker.sv =====
// ----------------------------------------------------------------------------
// hbte_checker
// Port-level checks of the encoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbte_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input hbte_pkg::result_t result_o
);

  // No result is offered in the cycle after a reset edge
  `HBTE_ASSERT_RST(a_empty_in_reset, !rst_ni |=> empty, "result offered during reset")

  // A waiting transaction holds until taken
  `HBTE_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(result_o)), "result changed while stalled")

  // A cell always ends on the glyph tail or the newline
  `HBTE_ASSERT(a_last_kind, (!empty && result_o.last_byte) |-> (result_o.out_byte == hbte_pkg::GLYPH_2 || result_o.out_byte == hbte_pkg::BYTE_NEWLINE), "bad final byte of cell")

  // The glyph lead byte is followed at once by its continuation byte
  `HBTE_ASSERT(a_glyph_seq, (!empty && pop && result_o.out_byte == hbte_pkg::GLYPH_0) |=> (!empty && result_o.out_byte == hbte_pkg::GLYPH_1), "broken glyph sequence")

endmodule

bind half_block_truecolor_text_encoder hbte_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

// ===== tb/tb_half_block_truecolor_text_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_half_block_truecolor_text_encoder
// Self-checking bench for the half-block truecolor text encoder. Cells go in
// through the push/full side and terminal bytes come out through the
// empty/pop side. Both sides pause at random. A short table of directed cells
// comes first, then random rows. Every byte and its last_byte flag are checked
// in order against typed-in text or a local model of the escape/glyph stream.
// ----------------------------------------------------------------------------
module tb_half_block_truecolor_text_encoder;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned CELL_TARGET    = 310;
  localparam int unsigned MAX_SHOWN      = 10;

  // Stream bytes
  localparam logic [7:0] ESC_CHAR   = 8'h1B;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] LAYER_FG   = 8'h33;
  localparam logic [7:0] LAYER_BG   = 8'h34;
  localparam logic [7:0] GLYPH_B0   = 8'hE2;
  localparam logic [7:0] GLYPH_B1   = 8'h96;
  localparam logic [7:0] GLYPH_B2   = 8'h80;

  // Channel values at the decimal width boundaries
  localparam logic [7:0] CHANNEL_CORNERS [6] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              push;
  logic              full;
  hbte_pkg::cell_t   cell_i;
  logic              empty;
  logic              pop;
  hbte_pkg::result_t result_o;

  half_block_truecolor_text_encoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .cell_i  (cell_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  // Color memory of the current text row
  logic        fg_known;
  logic        bg_known;
  logic [23:0] fg_color;
  logic [23:0] bg_color;

  logic [7:0]        cell_bytes[$];  // bytes of the cell being encoded
  hbte_pkg::result_t stream_q[$];    // terminal bytes still to come out
  hbte_pkg::cell_t   dir_cells[$];
  string             dir_text[$];    // typed-in stream, empty = use model

  bit          calm;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  int unsigned cells_sent;
  int unsigned rows_done;
  int unsigned absent_cells;
  int unsigned fg_escapes;
  int unsigned bg_escapes;
  int unsigned bytes_checked;

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("ERROR: %s", msg);
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Decimal, no leading zeros
  function automatic void append_decimal(input logic [7:0] v);
    if (v >= 8'd100) cell_bytes.push_back(DIGIT_BASE + v / 8'd100);
    if (v >= 8'd10) cell_bytes.push_back(DIGIT_BASE + (v / 8'd10) % 8'd10);
    cell_bytes.push_back(DIGIT_BASE + v % 8'd10);
  endfunction

  // ESC [ <layer> 8 ; 2 ; R ; G ; B m
  function automatic void append_color(input logic [7:0] layer, input logic [23:0] rgb);
    cell_bytes.push_back(ESC_CHAR);
    cell_bytes.push_back("[");
    cell_bytes.push_back(layer);
    cell_bytes.push_back("8");
    cell_bytes.push_back(";");
    cell_bytes.push_back("2");
    cell_bytes.push_back(";");
    append_decimal(rgb[23:16]);
    cell_bytes.push_back(";");
    append_decimal(rgb[15:8]);
    cell_bytes.push_back(";");
    append_decimal(rgb[7:0]);
    cell_bytes.push_back("m");
  endfunction

  // Encode one cell into cell_bytes and advance the row color memory
  function automatic void encode_cell(input hbte_pkg::cell_t c);
    logic [23:0] top_rgb;
    logic [23:0] bot_rgb;
    top_rgb = {c.top_red, c.top_green, c.top_blue};
    bot_rgb = c.bottom_absent ? 24'h0 : {c.bottom_red, c.bottom_green, c.bottom_blue};
    cell_bytes.delete();
    if (c.bottom_absent) absent_cells++;
    if (!fg_known || top_rgb != fg_color) begin
      append_color(LAYER_FG, top_rgb);
      fg_color = top_rgb;
      fg_known = 1'b1;
      fg_escapes++;
    end
    if (!bg_known || bot_rgb != bg_color) begin
      append_color(LAYER_BG, bot_rgb);
      bg_color = bot_rgb;
      bg_known = 1'b1;
      bg_escapes++;
    end
    cell_bytes.push_back(GLYPH_B0);
    cell_bytes.push_back(GLYPH_B1);
    cell_bytes.push_back(GLYPH_B2);
    // Row end: attribute reset, newline, forget colors
    if (c.row_end) begin
      cell_bytes.push_back(ESC_CHAR);
      cell_bytes.push_back("[");
      cell_bytes.push_back("0");
      cell_bytes.push_back("m");
      cell_bytes.push_back(LF_CHAR);
      fg_known = 1'b0;
      bg_known = 1'b0;
      fg_color = 24'h0;
      bg_color = 24'h0;
      rows_done++;
    end
  endfunction

  function automatic hbte_pkg::cell_t mk_cell(input logic [7:0] tr, input logic [7:0] tg,
                                              input logic [7:0] tb, input logic [7:0] br,
                                              input logic [7:0] bgr, input logic [7:0] bb,
                                              input logic absent, input logic rend);
    hbte_pkg::cell_t c;
    c = {tr, tg, tb, br, bgr, bb, absent, rend};
    return c;
  endfunction

  function automatic void add_row(input hbte_pkg::cell_t c, input string text);
    dir_cells.push_back(c);
    dir_text.push_back(text);
  endfunction

  // Keep the previous color, or pick corner or fully random channels
  function automatic logic [23:0] pick_color(input logic [23:0] prev);
    int unsigned r;
    logic [23:0] c;
    r = $urandom_range(0, 9);
    if (r < 4) return prev;
    for (int ch = 0; ch < 3; ch++) begin
      c[ch*8 +: 8] = (r < 7) ? CHANNEL_CORNERS[$urandom_range(0, 5)] : 8'($urandom);
    end
    return c;
  endfunction

  // Idle the sender; optionally hold off until the output has drained
  task automatic pace(input bit drain);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0 || drain) push <= 1'b0;
    if (drain) begin
      @(posedge clk_i);
      while (stream_q.size() != 0) @(posedge clk_i);
    end
    repeat (gap) @(posedge clk_i);
  endtask

  // One input transaction; queue the typed or modeled byte stream
  task automatic send_cell(input hbte_pkg::cell_t c, input string text);
    hbte_pkg::result_t r;
    cell_i <= c;
    push   <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    encode_cell(c);
    if (text.len() == 0) begin
      foreach (cell_bytes[i]) begin
        r.out_byte  = cell_bytes[i];
        r.last_byte = (i == cell_bytes.size() - 1);
        stream_q.push_back(r);
      end
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        r.out_byte  = text[i];
        r.last_byte = (i == text.len() - 1);
        stream_q.push_back(r);
      end
    end
    cells_sent++;
  endtask

  // Receiver: random pop stalls and in-order byte check
  initial begin
    int unsigned       hold;
    hbte_pkg::result_t want;
    hold = 0;
    pop  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (stream_q.size() == 0) begin
          note_error($sformatf("unexpected byte %02h (last_byte %0b)",
                               result_o.out_byte, result_o.last_byte));
        end else begin
          want = stream_q.pop_front();
          bytes_checked++;
          if (result_o.out_byte !== want.out_byte)
            note_error($sformatf("byte %0d: out_byte expected %02h, got %02h",
                                 bytes_checked, want.out_byte, result_o.out_byte));
          if (result_o.last_byte !== want.last_byte)
            note_error($sformatf("byte %0d: last_byte expected %0b, got %0b",
                                 bytes_checked, want.last_byte, result_o.last_byte));
        end
      end
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop  <= 1'b1;
        hold = draw_gap();
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d bytes outstanding",
                 idle_cycles, stream_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    hbte_pkg::cell_t c;
    logic [23:0]     top_rgb;
    logic [23:0]     bot_rgb;
    int unsigned     row_len;
    bit              odd_row;
    bit              drain;

    rst_ni        = 1'b0;
    push          = 1'b0;
    cell_i        = '0;
    calm          = 1'b0;
    fg_known      = 1'b0;
    bg_known      = 1'b0;
    fg_color      = 24'h0;
    bg_color      = 24'h0;
    err_cnt       = 0;
    idle_cycles   = 0;
    cells_sent    = 0;
    rows_done     = 0;
    absent_cells  = 0;
    fg_escapes    = 0;
    bg_escapes    = 0;
    bytes_checked = 0;
    top_rgb       = 24'h0;
    bot_rgb       = 24'h0;

    // Directed cells; typed streams where they are obvious
    add_row(mk_cell(0, 0, 0, 0, 0, 0, 0, 0),
            "\033[38;2;0;0;0m\033[48;2;0;0;0m\342\226\200");
    add_row(mk_cell(0, 0, 0, 0, 0, 0, 0, 0), "\342\226\200");
    // Longest cell: both escapes at three digits plus row end
    add_row(mk_cell(255, 255, 255, 255, 255, 255, 0, 1),
            "\033[38;2;255;255;255m\033[48;2;255;255;255m\342\226\200\033[0m\n");
    add_row(mk_cell(0, 0, 0, 0, 0, 0, 0, 0),
            "\033[38;2;0;0;0m\033[48;2;0;0;0m\342\226\200");
    // Missing lower pixel reads as black, bottom fields ignored
    add_row(mk_cell(0, 0, 0, 255, 255, 255, 1, 0), "\342\226\200");
    add_row(mk_cell(9, 10, 99, 100, 199, 200, 0, 0), "");
    add_row(mk_cell(9, 10, 99, 7, 7, 7, 0, 0), "");
    add_row(mk_cell(1, 2, 3, 7, 7, 7, 0, 0), "");
    add_row(mk_cell(1, 2, 3, 5, 6, 7, 1, 0), "");
    add_row(mk_cell(255, 0, 128, 0, 0, 0, 1, 1), "");
    add_row(mk_cell(0, 0, 0, 0, 0, 0, 0, 1),
            "\033[38;2;0;0;0m\033[48;2;0;0;0m\342\226\200\033[0m\n");
    add_row(mk_cell(170, 85, 170, 85, 170, 85, 0, 0), "");
    add_row(mk_cell(85, 170, 85, 170, 85, 170, 0, 0), "");
    add_row(mk_cell(255, 255, 255, 0, 0, 0, 0, 0), "");
    add_row(mk_cell(255, 255, 255, 0, 0, 0, 0, 1), "\342\226\200\033[0m\n");

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_cells[i]) begin
      pace(1'b0);
      send_cell(dir_cells[i], dir_text[i]);
    end

    // Random rows; colors often repeat so escapes get suppressed
    drain = 1'b1;
    while (cells_sent < CELL_TARGET) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      odd_row = ($urandom_range(0, 4) == 0);
      calm    = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < row_len; k++) begin
        top_rgb = pick_color(top_rgb);
        bot_rgb = pick_color(bot_rgb);
        c = {top_rgb, bot_rgb, odd_row || ($urandom_range(0, 15) == 0),
             (k == row_len - 1) ? 1'b1 : 1'b0};
        pace(drain && k == 0);
        send_cell(c, "");
        drain = ($urandom_range(0, 19) == 0);
      end
    end

    push <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (stream_q.size() != 0) note_error($sformatf("%0d bytes never came out", stream_q.size()));

    $display("Sent %0d cells in %0d finished rows, %0d without a lower pixel", cells_sent,
             rows_done, absent_cells);
    $display("Checked %0d bytes with %0d fg and %0d bg escapes; %0d mismatches", bytes_checked,
             fg_escapes, bg_escapes, err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
